FILE: sv/rplu_pkg.sv
// ----------------------------------------------------------------------------
// rplu_pkg
// Types and constants shared by the ring preference-list lookup unit.
// ----------------------------------------------------------------------------
`default_nettype none

package rplu_pkg;

    localparam int unsigned ID_W    = 4;   // physical node id width
    localparam int unsigned VIDX_W  = 4;   // virtual node index width
    localparam int unsigned HASH_W  = 64;  // key hash width
    localparam int unsigned LSIZE_W = 5;   // preference list size register width
    localparam int unsigned SEEN_W  = 1 << ID_W;

    localparam logic [LSIZE_W-1:0] LSIZE_RESET = 5'd3;
    localparam logic [LSIZE_W-1:0] LSIZE_MAX   = 5'd16;

    localparam logic FUNC_WRITE  = 1'b0;
    localparam logic FUNC_LOOKUP = 1'b1;

    typedef struct packed {
        logic              func;
        logic [VIDX_W-1:0] vnode_index;
        logic [ID_W-1:0]   owner_id;
        logic [HASH_W-1:0] key_hash;
    } t_in_item;

    typedef struct packed {
        logic [ID_W-1:0] node_id;
        logic [3:0]      list_position;
        logic            last;
    } t_out_item;

    // controller -> datapath
    typedef struct packed {
        logic accept;       // input word taken this cycle
        logic search_step;  // compare ring position with hash, advance
        logic walk_start;   // load start position, issue first read
        logic walk_step;    // consume one ring entry
        logic flush;        // move held entry to output as last
    } t_dp_cmd;

    // datapath -> controller
    typedef struct packed {
        logic search_done;
        logic walk_new;     // current entry has an owner not yet listed
        logic walk_end;     // current entry finishes the walk
        logic pend_valid;   // an entry is held back for its last flag
        logic out_free;     // output register can take a word
    } t_dp_status;

endpackage : rplu_pkg

`default_nettype wire

FILE: sv/rplu_ctrl.sv
// ----------------------------------------------------------------------------
// rplu_ctrl
// Sequencer for writes, ring search, ring walk and final flush.
// ----------------------------------------------------------------------------
`default_nettype none

module rplu_ctrl
    import rplu_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_in_valid,
    input  wire logic       i_func,
    output logic            o_in_ready,
    input  wire t_dp_status i_sts,
    output t_dp_cmd         o_cmd
);

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_SEARCH = 2'd1;
    localparam logic [1:0] ST_WALK   = 2'd2;
    localparam logic [1:0] ST_FLUSH  = 2'd3;

    logic [1:0] r_state;
    logic [1:0] n_state;
    logic       stall;

    // a new owner cannot displace the held entry while the output is full
    assign stall = i_sts.walk_new && i_sts.pend_valid && !i_sts.out_free;

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    if (i_func == FUNC_LOOKUP) begin
                        n_state = ST_SEARCH;
                    end
                end
            end
            ST_SEARCH: begin
                o_cmd.search_step = 1'b1;
                if (i_sts.search_done) begin
                    o_cmd.walk_start = 1'b1;
                    n_state          = ST_WALK;
                end
            end
            ST_WALK: begin
                if (!stall) begin
                    o_cmd.walk_step = 1'b1;
                    if (i_sts.walk_end) begin
                        n_state = ST_FLUSH;
                    end
                end
            end
            ST_FLUSH: begin
                if (i_sts.out_free) begin
                    o_cmd.flush = 1'b1;
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule : rplu_ctrl

`default_nettype wire

FILE: sv/rplu_dp.sv
// ----------------------------------------------------------------------------
// rplu_dp
// Owner table, ring search, duplicate filter and output register.
// ----------------------------------------------------------------------------
`default_nettype none

module rplu_dp
    import rplu_pkg::*;
#(
    parameter int unsigned NUM_VNODES = 16,
    parameter int unsigned MAX_NODES  = 16
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire t_in_item           i_in,
    input  wire logic               i_cfg_valid,
    input  wire logic [LSIZE_W-1:0] i_cfg_data,
    input  wire t_dp_cmd            i_cmd,
    output t_dp_status              o_sts,
    output logic                    o_out_valid,
    input  wire logic               i_out_ready,
    output t_out_item               o_out
);

    localparam int unsigned AW = (NUM_VNODES > 1) ? $clog2(NUM_VNODES) : 1;
    localparam logic [AW-1:0] LAST_IDX = AW'(NUM_VNODES - 1);
    localparam logic [HASH_W-1:0] STEP =
        64'hFFFF_FFFF_FFFF_FFFF / 64'(NUM_VNODES);

    // owner table with per-entry valid bits (unwritten entry reads as node 0)
    logic [ID_W-1:0]       r_mem [NUM_VNODES];
    logic [NUM_VNODES-1:0] r_vld;
    logic [ID_W-1:0]       r_rd_data;
    logic                  r_rd_vld;

    logic [LSIZE_W-1:0] r_lsize;
    logic [LSIZE_W-1:0] r_want;
    logic [HASH_W-1:0]  r_hash;
    logic [HASH_W-1:0]  r_acc;
    logic [AW-1:0]      r_pos;
    logic [AW-1:0]      r_visit;
    logic [SEEN_W-1:0]  r_seen;
    logic [LSIZE_W-1:0] r_count;
    logic               r_pend_valid;
    logic [ID_W-1:0]    r_pend_id;
    logic [3:0]         r_pend_pos;
    logic               r_out_valid;
    t_out_item          r_out;

    logic               wr_en;
    logic [AW-1:0]      wr_addr;
    logic               rd_en;
    logic [AW-1:0]      rd_addr;
    logic               hit;
    logic [AW-1:0]      start_pos;
    logic [AW-1:0]      next_pos;
    logic [ID_W-1:0]    owner;
    logic               is_new;
    logic [LSIZE_W-1:0] count_inc;
    logic [LSIZE_W-1:0] want_eff;
    logic               out_free;
    logic               push_out;

    assign wr_en = i_cmd.accept && (i_in.func == FUNC_WRITE)
                   && ({28'd0, i_in.vnode_index} < 32'(NUM_VNODES))
                   && ({28'd0, i_in.owner_id} < 32'(MAX_NODES));
    assign wr_addr = AW'(i_in.vnode_index);

    assign hit       = (r_acc >= r_hash);
    assign start_pos = hit ? r_pos : '0;
    assign next_pos  = (r_pos == LAST_IDX) ? '0 : r_pos + AW'(1);

    assign rd_en   = i_cmd.walk_start || i_cmd.walk_step;
    assign rd_addr = i_cmd.walk_start ? start_pos : next_pos;

    assign owner     = r_rd_vld ? r_rd_data : '0;
    assign is_new    = !r_seen[owner];
    assign count_inc = r_count + LSIZE_W'(1);
    assign out_free  = !r_out_valid || i_out_ready;
    assign push_out  = i_cmd.walk_step && is_new && r_pend_valid;

    always_comb begin
        if (r_lsize == '0) begin
            want_eff = LSIZE_W'(1);
        end else if (r_lsize > LSIZE_MAX) begin
            want_eff = LSIZE_MAX;
        end else begin
            want_eff = r_lsize;
        end
    end

    assign o_sts.search_done = hit || (r_pos == LAST_IDX);
    assign o_sts.walk_new    = is_new;
    assign o_sts.walk_end    = (r_visit == LAST_IDX) || (is_new && count_inc == r_want);
    assign o_sts.pend_valid  = r_pend_valid;
    assign o_sts.out_free    = out_free;

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= i_in.owner_id;
        end
        if (rd_en) begin
            r_rd_data <= r_mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld    <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            if (wr_en) begin
                r_vld[wr_addr] <= 1'b1;
            end
            if (rd_en) begin
                r_rd_vld <= r_vld[rd_addr];
            end
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lsize      <= LSIZE_RESET;
            r_pend_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_lsize <= i_cfg_data;
            end
            if (i_cmd.walk_start || i_cmd.flush) begin
                r_pend_valid <= 1'b0;
            end else if (i_cmd.walk_step && is_new) begin
                r_pend_valid <= 1'b1;
            end
            if (push_out || i_cmd.flush) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_hash  <= i_in.key_hash;
            r_acc   <= '0;
            r_pos   <= '0;
            r_want  <= want_eff;
        end
        if (i_cmd.search_step && !o_sts.search_done) begin
            r_acc <= r_acc + STEP;
            r_pos <= r_pos + AW'(1);
        end
        if (i_cmd.walk_start) begin
            r_pos   <= start_pos;
            r_visit <= '0;
            r_seen  <= '0;
            r_count <= '0;
        end
        if (i_cmd.walk_step) begin
            r_pos   <= next_pos;
            r_visit <= r_visit + AW'(1);
            if (is_new) begin
                r_seen[owner] <= 1'b1;
                r_count       <= count_inc;
                r_pend_id     <= owner;
                r_pend_pos    <= r_count[3:0];
            end
        end
        if (push_out) begin
            r_out.node_id       <= r_pend_id;
            r_out.list_position <= r_pend_pos;
            r_out.last          <= 1'b0;
        end else if (i_cmd.flush) begin
            r_out.node_id       <= r_pend_id;
            r_out.list_position <= r_pend_pos;
            r_out.last          <= 1'b1;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

endmodule : rplu_dp

`default_nettype wire

FILE: sv/ring_preference_list_lookup_unit.sv
// ----------------------------------------------------------------------------
// ring_preference_list_lookup_unit
// Consistent-hashing ring: owner writes and preference-list lookups.
// ----------------------------------------------------------------------------
//
//  channel  | direction | handshake                 | word
//  ---------+-----------+---------------------------+-----------------------
//  in       | input     | i_in_valid / o_in_ready   | t_in_item
//  out      | output    | o_out_valid / i_out_ready | t_out_item
//  cfg      | input     | i_cfg_valid / o_cfg_ready | pref_list_size, 5 bits
//
//  A write word is done when it is accepted. A lookup runs an accept,
//  a search (one 64-bit ring position compare per cycle), a walk (one
//  owner table read per cycle unless a full output register holds it)
//  and a flush; the next word is taken only once the flush is done.
//  Reset is synchronous, active low; the owner table reads as node 0 until
//  written, and pref_list_size returns to 3.
//  A full output register holds the walk when a new owner must be passed on.
// ----------------------------------------------------------------------------
`default_nettype none

module ring_preference_list_lookup_unit
    import rplu_pkg::*;
#(
    parameter int unsigned NUM_VNODES = 16,
    parameter int unsigned MAX_NODES  = 16
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    // item input
    input  wire logic               i_in_valid,
    output logic                    o_in_ready,
    input  wire t_in_item           i_in,
    // result output
    output logic                    o_out_valid,
    input  wire logic               i_out_ready,
    output t_out_item               o_out,
    // configuration write
    input  wire logic               i_cfg_valid,
    output logic                    o_cfg_ready,
    input  wire logic [LSIZE_W-1:0] i_cfg_data
);

    t_dp_cmd    cmd;
    t_dp_status sts;

    // register writes land in any cycle
    assign o_cfg_ready = 1'b1;

    // sequence the search and walk
    rplu_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_func     (i_in.func),
        .o_in_ready (o_in_ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    // hold the table, filter duplicate owners, drive the output register
    rplu_dp #(
        .NUM_VNODES (NUM_VNODES),
        .MAX_NODES  (MAX_NODES)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (i_in),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_data  (i_cfg_data),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out       (o_out)
    );

endmodule : ring_preference_list_lookup_unit

`default_nettype wire
